// ----- rtl/core/mevq_pkg.sv -----
// ----------------------------------------------------------------------------
// mevq_pkg
// Shared types, register indexes and reset values of the movement qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mevq_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int HOLD_W = 16;
  localparam int COOL_W = 20;
  localparam int GAP_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISING_SENSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAP   = 3'd6;

  localparam int THRESHOLD_RESET = 2048;
  localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd100;
  localparam logic [COOL_W-1:0] COOLDOWN_RESET = COOL_W'(1000 * 3);
  localparam logic [GAP_W-1:0]  GAP_RESET      = 16'd50;

  typedef struct packed {
    logic              rising_sense;
    logic              use_level;
    logic              skip_hold;
    logic [HOLD_W-1:0] hold_ticks;
    logic [COOL_W-1:0] cooldown_ticks;
    logic [GAP_W-1:0]  sample_gap;
  } mevq_cfg_t;

  typedef struct packed {
    logic report;
    logic sampled;
    logic moving;
  } mevq_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/mevq_cfg.sv -----
// ----------------------------------------------------------------------------
// mevq_cfg
// Configuration register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mevq_cfg #(
  parameter int SAMPLE_BITS = mevq_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mevq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mevq_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic      [SAMPLE_BITS-1:0]          threshold,
  output mevq_pkg::mevq_cfg_t                  cfg
);

  logic [SAMPLE_BITS-1:0] threshold_r;
  mevq_pkg::mevq_cfg_t    cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r          <= SAMPLE_BITS'(mevq_pkg::THRESHOLD_RESET);
      cfg_r.rising_sense   <= 1'b0;
      cfg_r.use_level      <= 1'b0;
      cfg_r.skip_hold      <= 1'b0;
      cfg_r.hold_ticks     <= mevq_pkg::HOLD_RESET;
      cfg_r.cooldown_ticks <= mevq_pkg::COOLDOWN_RESET;
      cfg_r.sample_gap     <= mevq_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mevq_pkg::REG_THRESHOLD:    threshold_r <= cfg_data[SAMPLE_BITS-1:0];
        mevq_pkg::REG_RISING_SENSE: cfg_r.rising_sense <= cfg_data[0];
        mevq_pkg::REG_USE_LEVEL:    cfg_r.use_level <= cfg_data[0];
        mevq_pkg::REG_SKIP_HOLD:    cfg_r.skip_hold <= cfg_data[0];
        mevq_pkg::REG_HOLD_TICKS:   cfg_r.hold_ticks <= cfg_data[mevq_pkg::HOLD_W-1:0];
        mevq_pkg::REG_COOLDOWN:     cfg_r.cooldown_ticks <= cfg_data[mevq_pkg::COOL_W-1:0];
        mevq_pkg::REG_SAMPLE_GAP:   cfg_r.sample_gap <= cfg_data[mevq_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign threshold = threshold_r;
  assign cfg       = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/core/mevq_eval.sv -----
// ----------------------------------------------------------------------------
// mevq_eval
// Tick time base, sample gating, classification and report qualification.
// ----------------------------------------------------------------------------
`default_nettype none

module mevq_eval #(
  parameter int SAMPLE_BITS = mevq_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = mevq_pkg::TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   level,
  input  wire logic [SAMPLE_BITS-1:0] threshold,
  input  wire mevq_pkg::mevq_cfg_t    cfg,
  output mevq_pkg::mevq_result_t      result
);

  localparam int CMP_W = (TIME_BITS > mevq_pkg::COOL_W) ? TIME_BITS : mevq_pkg::COOL_W;

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] last_sample_r, last_sample_nxt;
  logic [TIME_BITS-1:0] last_report_r, last_report_nxt;
  logic [TIME_BITS-1:0] hold_start_r, hold_start_nxt;
  logic                 hold_active_r, hold_active_nxt;
  logic                 armed_r, armed_nxt;

  logic [TIME_BITS-1:0] el_sample, el_report, el_hold;
  logic take, moving, cool_ok, hold_ok, report;

  always_comb begin
    now_nxt   = now_r + TIME_BITS'(1);
    el_sample = now_nxt - last_sample_r;
    el_report = now_nxt - last_report_r;
    el_hold   = now_nxt - hold_start_r;

    take    = el_sample > TIME_BITS'(cfg.sample_gap);
    cool_ok = CMP_W'(el_report) >= CMP_W'(cfg.cooldown_ticks);
    hold_ok = el_hold >= TIME_BITS'(cfg.hold_ticks);

    if (cfg.use_level) begin
      moving = take & level;
    end else if (cfg.rising_sense) begin
      moving = take & (sample > threshold);
    end else begin
      moving = take & (sample < threshold);
    end

    report          = 1'b0;
    last_sample_nxt = last_sample_r;
    last_report_nxt = last_report_r;
    hold_start_nxt  = hold_start_r;
    hold_active_nxt = hold_active_r;
    armed_nxt       = armed_r;

    if (take) begin
      last_sample_nxt = now_nxt;
      if (moving) begin
        // blocked detector leaves the hold alone
        if (armed_r && cool_ok) begin
          if (cfg.skip_hold) begin
            report = 1'b1;
          end else if (hold_active_r && hold_ok) begin
            report          = 1'b1;
            hold_active_nxt = 1'b0;
          end else if (!hold_active_r) begin
            hold_active_nxt = 1'b1;
            hold_start_nxt  = now_nxt;
          end
          if (report) begin
            armed_nxt       = 1'b0;
            last_report_nxt = now_nxt;
          end
        end
      end else begin
        armed_nxt       = 1'b1;
        hold_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      last_sample_r <= '0;
      last_report_r <= '0;
      hold_start_r  <= '0;
      hold_active_r <= 1'b0;
      armed_r       <= 1'b1;
    end else if (fire) begin
      now_r         <= now_nxt;
      last_sample_r <= last_sample_nxt;
      last_report_r <= last_report_nxt;
      hold_start_r  <= hold_start_nxt;
      hold_active_r <= hold_active_nxt;
      armed_r       <= armed_nxt;
    end
  end

  assign result.report  = report;
  assign result.sampled = take;
  assign result.moving  = moving;

endmodule

`default_nettype wire

// ----- rtl/core/movement_event_qualifier.sv -----
// ----------------------------------------------------------------------------
// movement_event_qualifier
// Debounced threshold detector with hold time and report cooldown.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ channel is one millisecond tick carrying a sensor
//   sample and a digital level. Every request yields exactly one result on the
//   out_ channel: report, sampled and moving for that tick. The time base
//   counts accepted requests, not clock cycles.
//   A request lands in the input register, is evaluated against the detector
//   state, and the result is registered.
//   Throughput is one request per cycle; the input register and the result
//   register move together whenever the result register is empty or taken.
//   When the receiver stalls, the result holds and in_stall rises once the
//   input register is also full; nothing is dropped.
//   Reset (rst_n low, synchronous) empties both registers, clears the time
//   base and hold, arms the detector and loads the register reset values.
//   Configuration writes on cfg_ take effect at the next edge, and must only
//   be issued while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module movement_event_qualifier #(
  parameter int SAMPLE_BITS = mevq_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = mevq_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [SAMPLE_BITS-1:0]          in_sample,
  input  wire logic                            in_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_report,
  output logic                                 out_sampled,
  output logic                                 out_moving,
  input  wire logic                            cfg_we,
  input  wire logic [mevq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mevq_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [SAMPLE_BITS-1:0] threshold;
  mevq_pkg::mevq_cfg_t    cfg;
  mevq_pkg::mevq_result_t result;

  logic                   stage_valid_r;
  logic [SAMPLE_BITS-1:0] stage_sample_r;
  logic                   stage_level_r;
  logic                   out_valid_r;
  mevq_pkg::mevq_result_t out_result_r;
  logic                   advance;
  logic                   fire;

  mevq_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .threshold (threshold),
    .cfg       (cfg)
  );

  mevq_eval #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .sample    (stage_sample_r),
    .level     (stage_level_r),
    .threshold (threshold),
    .cfg       (cfg),
    .result    (result)
  );

  // advance the pipe when the result slot is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = stage_valid_r && advance;
  assign in_stall = stage_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // refill the input register whenever it is empty or moving on
      if (!in_stall) begin
        stage_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= stage_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_sample_r <= in_sample;
      stage_level_r  <= in_level;
    end
    if (fire) begin
      out_result_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_report  = out_result_r.report;
  assign out_sampled = out_result_r.sampled;
  assign out_moving  = out_result_r.moving;

endmodule

`default_nettype wire

// ----- dv/movement_event_qualifier_checker.sv -----
// ----------------------------------------------------------------------------
// movement_event_qualifier_checker
// Watches the request, result and register ports of the movement qualifier,
// keeps its own copy of the detector state and timing registers, works out
// the result of every accepted request and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module movement_event_qualifier_checker
  import mevq_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [SAMPLE_BITS_DEF-1:0] in_sample,
  input  wire logic                       in_level,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic                       out_report,
  input  wire logic                       out_sampled,
  input  wire logic                       out_moving,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  output int                              mismatch_count,
  output int                              pending_results
);

  typedef logic [TIME_BITS_DEF-1:0] tick_t;

  logic [SAMPLE_BITS_DEF-1:0] threshold_q;
  mevq_cfg_t                  timing_q;

  tick_t tick_now;
  tick_t last_sample_tick;
  tick_t last_report_tick;
  tick_t hold_start_tick;
  logic  hold_on;
  logic  armed_q;

  mevq_result_t awaited_ticks[$];
  int           fail_total;

  // Advance the time base by one tick and work out this tick's result.
  task automatic advance_tick(input logic [SAMPLE_BITS_DEF-1:0] smp, input logic lvl,
                              output mevq_result_t res);
    logic mov;
    res = '0;
    tick_now = tick_now + 1'b1;
    if (tick_t'(tick_now - last_sample_tick) > tick_t'(timing_q.sample_gap)) begin
      res.sampled = 1'b1;
      last_sample_tick = tick_now;
      if (timing_q.use_level) begin
        mov = lvl;
      end else if (timing_q.rising_sense) begin
        mov = smp > threshold_q;
      end else begin
        mov = smp < threshold_q;
      end
      res.moving = mov;
      if (mov) begin
        // blocked while disarmed or cooling down: hold neither started nor checked
        if (armed_q &&
            tick_t'(tick_now - last_report_tick) >= tick_t'(timing_q.cooldown_ticks)) begin
          if (timing_q.skip_hold) begin
            res.report = 1'b1;
          end else if (hold_on &&
                       tick_t'(tick_now - hold_start_tick) >= tick_t'(timing_q.hold_ticks)) begin
            res.report = 1'b1;
            hold_on = 1'b0;
          end else if (!hold_on) begin
            hold_on = 1'b1;
            hold_start_tick = tick_now;
          end
          if (res.report) begin
            armed_q = 1'b0;
            last_report_tick = tick_now;
          end
        end
      end else begin
        armed_q = 1'b1;
        hold_on = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    mevq_result_t got;
    mevq_result_t want;
    if (!rst_n) begin
      threshold_q             = SAMPLE_BITS_DEF'(THRESHOLD_RESET);
      timing_q.rising_sense   = 1'b0;
      timing_q.use_level      = 1'b0;
      timing_q.skip_hold      = 1'b0;
      timing_q.hold_ticks     = HOLD_RESET;
      timing_q.cooldown_ticks = COOLDOWN_RESET;
      timing_q.sample_gap     = GAP_RESET;
      tick_now         = '0;
      last_sample_tick = '0;
      last_report_tick = '0;
      hold_start_tick  = '0;
      hold_on          = 1'b0;
      armed_q          = 1'b1;
      awaited_ticks.delete();
      fail_total = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.report  = out_report;
        got.sampled = out_sampled;
        got.moving  = out_moving;
        if (awaited_ticks.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("[%0t] result with no request pending: report=%b sampled=%b moving=%b",
                     $realtime, got.report, got.sampled, got.moving);
          end
        end else begin
          want = awaited_ticks.pop_front();
          if (got.report !== want.report || got.sampled !== want.sampled ||
              got.moving !== want.moving) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display({"[%0t] result mismatch: expected report=%b sampled=%b moving=%b,",
                        " got report=%b sampled=%b moving=%b"},
                       $realtime, want.report, want.sampled, want.moving,
                       got.report, got.sampled, got.moving);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_tick(in_sample, in_level, want);
        awaited_ticks.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:    threshold_q = cfg_data[SAMPLE_BITS_DEF-1:0];
          REG_RISING_SENSE: timing_q.rising_sense = cfg_data[0];
          REG_USE_LEVEL:    timing_q.use_level = cfg_data[0];
          REG_SKIP_HOLD:    timing_q.skip_hold = cfg_data[0];
          REG_HOLD_TICKS:   timing_q.hold_ticks = cfg_data[HOLD_W-1:0];
          REG_COOLDOWN:     timing_q.cooldown_ticks = cfg_data[COOL_W-1:0];
          REG_SAMPLE_GAP:   timing_q.sample_gap = cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count  <= fail_total;
    pending_results <= awaited_ticks.size();
  end

endmodule

`default_nettype wire

// ----- dv/movement_event_qualifier_test.sv -----
// ----------------------------------------------------------------------------
// movement_event_qualifier_test
// Drives millisecond tick requests and register settings into the movement
// qualifier: a directed start over the special cases, then random phases with
// runs of moving and still samples under changing settings and idle patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module movement_event_qualifier_test;

  import mevq_pkg::*;

  localparam int SBITS          = SAMPLE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_HOLD  = 60;
  localparam int PHASE_TICKS    = 140;

  // index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SBITS-1:0]      in_sample = '0;
  logic                  in_level = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_report;
  logic                  out_sampled;
  logic                  out_moving;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_count;
  int pending_results;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pressure_req = 0;
  int pressure_ack = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // settings last written, used to shape samples
  logic [SBITS-1:0] thr_set = SBITS'(THRESHOLD_RESET);
  logic             rise_set = 1'b0;
  logic             level_set = 1'b0;
  int               run_left = 0;
  logic             run_moving = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  movement_event_qualifier u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .in_level    (in_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_report  (out_report),
    .out_sampled (out_sampled),
    .out_moving  (out_moving),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  movement_event_qualifier_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_level        (in_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_report      (out_report),
    .out_sampled     (out_sampled),
    .out_moving      (out_moving),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Result side: random stall, or a long hold-off when asked for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (pressure_req != pressure_ack) begin
      pressure_ack <= pressure_req;
      stall_left   <= PRESSURE_HOLD;
      out_stall    <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [SBITS-1:0] thr, input logic rise, input logic lvl,
                              input logic skip, input logic [HOLD_W-1:0] hold,
                              input logic [COOL_W-1:0] cool, input logic [GAP_W-1:0] gap);
    thr_set   = thr;
    rise_set  = rise;
    level_set = lvl;
    write_reg(REG_THRESHOLD,    CFG_DATA_W'(thr));
    write_reg(REG_RISING_SENSE, CFG_DATA_W'(rise));
    write_reg(REG_USE_LEVEL,    CFG_DATA_W'(lvl));
    write_reg(REG_SKIP_HOLD,    CFG_DATA_W'(skip));
    write_reg(REG_HOLD_TICKS,   CFG_DATA_W'(hold));
    write_reg(REG_COOLDOWN,     CFG_DATA_W'(cool));
    write_reg(REG_SAMPLE_GAP,   CFG_DATA_W'(gap));
    write_reg(REG_UNUSED,       CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Offer one tick request and return once it is taken.
  task automatic send_tick(input logic [SBITS-1:0] smp, input logic lvl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    in_level  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for every result to come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly runs of moving or still samples under the current setting, some noise.
  task automatic random_tick();
    logic [SBITS-1:0] smp;
    logic             lvl;
    int               pick;
    if (run_left == 0) begin
      run_moving = 1'($urandom_range(0, 1));
      run_left   = $urandom_range(1, 30);
    end
    run_left--;
    smp  = SBITS'($urandom_range(0, (1 << SBITS) - 1));
    lvl  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 90 && level_set) begin
      lvl = run_moving;
    end else if (pick < 90 && rise_set) begin
      if (run_moving && thr_set != '1) begin
        smp = SBITS'($urandom_range(thr_set + 1, (1 << SBITS) - 1));
      end else if (!run_moving) begin
        smp = (pick < 8) ? thr_set : SBITS'($urandom_range(0, thr_set));
      end
    end else if (pick < 90) begin
      if (run_moving && thr_set != '0) begin
        smp = SBITS'($urandom_range(0, thr_set - 1));
      end else if (!run_moving) begin
        smp = (pick < 8) ? thr_set : SBITS'($urandom_range(thr_set, (1 << SBITS) - 1));
      end
    end
    send_tick(smp, lvl);
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no sample before the gap has passed
    send_tick('0, 1'b0);
    send_tick('1, 1'b1);
    send_tick(SBITS'(THRESHOLD_RESET), 1'b0);
    drain();

    // falling compare, zero hold: first moving sample only starts the hold
    apply_config(SBITS'(THRESHOLD_RESET), 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send_tick('1, 1'b1);
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    send_tick('0, 1'b0);
    send_tick(SBITS'(THRESHOLD_RESET), 1'b1);
    send_tick(SBITS'(THRESHOLD_RESET - 1), 1'b0);
    drain();

    // rising compare at the bottom, report without hold
    apply_config('0, 1'b1, 1'b0, 1'b1, '0, '0, '0);
    send_tick('0, 1'b1);
    send_tick('1, 1'b0);
    send_tick(SBITS'(1), 1'b1);
    send_tick('0, 1'b0);
    send_tick(SBITS'(1), 1'b0);
    drain();

    // level mode with gap, hold and cooldown
    apply_config('1, 1'b0, 1'b1, 1'b0, HOLD_W'(1), COOL_W'(2), GAP_W'(1));
    send_tick('0, 1'b1);
    send_tick('1, 1'b1);
    send_tick('0, 1'b1);
    send_tick('1, 1'b1);
    send_tick('0, 1'b1);
    send_tick('1, 1'b0);
    send_tick('0, 1'b0);
    send_tick('1, 1'b1);
    send_tick('0, 1'b1);
    drain();

    for (phase = 0; phase < 7; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 13;
        recv_idle_pct = 83;
      end else if (phase < 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        1: apply_config(SBITS'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'b0, '1,
                        COOL_W'($urandom_range(0, 30)), GAP_W'($urandom_range(0, 3)));
        3: apply_config('1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), HOLD_W'($urandom_range(0, 12)), '1,
                        GAP_W'($urandom_range(0, 3)));
        5: apply_config('0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), '0, '0, '0);
        6: apply_config('1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), '1, '1, '1);
        default: apply_config(SBITS'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              HOLD_W'($urandom_range(0, 12)), COOL_W'($urandom_range(0, 30)),
                              GAP_W'($urandom_range(0, 3)));
      endcase
      // hold the result side off while requests keep coming
      if (phase == 4) pressure_req++;
      repeat ((phase == 6) ? 20 : PHASE_TICKS) random_tick();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/mevq_pkg.sv
rtl/core/mevq_cfg.sv
rtl/core/mevq_eval.sv
rtl/core/movement_event_qualifier.sv
dv/movement_event_qualifier_checker.sv
dv/movement_event_qualifier_test.sv
